[src/hta_pkg.sv]
// hta_pkg: shared types and constants of the hsv to argb converter
// no dependencies; imported by every module of the block
package hta_pkg;

  // fixed field widths
  localparam int unsigned HUE_W     = 15;
  localparam int unsigned LEVEL_W   = 9;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned ARGB_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned V255_W    = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b1;

  // q1.8 unity level and the opaque alpha byte
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 9'd256;
  localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;

  // degrees per sector
  localparam int unsigned SPAN_DEG = 60;

  // reciprocal constants: x / 60 for x < 2^15, x / 6 for x < 1024,
  // and x / 60 for the 14-bit scaled channel value
  localparam int unsigned HUE_DIV_MUL = 34953;
  localparam int unsigned HUE_DIV_SH  = 21;
  localparam int unsigned DIV6_MUL    = 1366;
  localparam int unsigned DIV6_SH     = 13;
  localparam int unsigned CH_DIV_MUL  = 17477;
  localparam int unsigned CH_DIV_SH   = 20;

  // widths of the quotients above
  localparam int unsigned QA_W = 10;
  localparam int unsigned QQ_W = 7;
  localparam int unsigned M_W  = 14;

  // 60-degree sector of the hue circle
  typedef enum logic [2:0] {
    SECT_RED_YELLOW  = 3'd0,
    SECT_YELLOW_GRN  = 3'd1,
    SECT_GRN_CYAN    = 3'd2,
    SECT_CYAN_BLUE   = 3'd3,
    SECT_BLUE_MAG    = 3'd4,
    SECT_MAG_RED     = 3'd5
  } sector_e;

  // control that travels with a beat out of the hue splitter
  typedef struct packed {
    logic    vld;
    sector_e sector;
  } split_ctl_t;

endpackage

[src/hta_hue_split.sv]
// hta_hue_split: three-stage hue reduction into a sector and an in-sector offset
// depends on hta_pkg
module hta_hue_split import hta_pkg::*; #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic [HUE_W-1:0]          hue_i,
  output split_ctl_t                ctl_o,
  output logic [HUE_FRAC_BITS+5:0]  rem_o
);

  localparam int unsigned RW = HUE_FRAC_BITS + 6;
  localparam int unsigned PA_W = HUE_W + 16;
  localparam int unsigned PB_W = QA_W + 11;
  localparam logic [HUE_W-1:0] LOW_MASK = HUE_W'((1 << HUE_FRAC_BITS) - 1);

  // stage a: whole degrees and their quotient by 60
  logic [HUE_W-1:0] deg_d, deg_q, low_d, low_q;
  logic [QA_W-1:0]  qa_d, qa_q;
  logic [PA_W-1:0]  prod_a;
  logic             vld_a_q;

  assign deg_d  = hue_i >> HUE_FRAC_BITS;
  assign low_d  = hue_i & LOW_MASK;
  assign prod_a = PA_W'(deg_d) * PA_W'(HUE_DIV_MUL);
  assign qa_d   = prod_a[HUE_DIV_SH +: QA_W];

  always_ff @(posedge clk_i) begin
    deg_q <= deg_d;
    low_q <= low_d;
    qa_q  <= qa_d;
  end

  // stage b: offset inside the sector and quotient by 6
  logic [5:0]      rem60;
  logic [RW-1:0]   r_d, r_q;
  logic [PB_W-1:0] prod_b;
  logic [QQ_W-1:0] qq_d, qq_q;
  logic [QA_W-1:0] qa_b_q;
  logic            vld_b_q;

  assign rem60  = 6'(deg_q - HUE_W'(qa_q) * HUE_W'(SPAN_DEG));
  assign r_d    = (RW'(rem60) << HUE_FRAC_BITS) | RW'(low_q);
  assign prod_b = PB_W'(qa_q) * PB_W'(DIV6_MUL);
  assign qq_d   = prod_b[DIV6_SH +: QQ_W];

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    qq_q   <= qq_d;
    qa_b_q <= qa_q;
  end

  // stage c: sector is the turn count by 60 degrees modulo 6
  logic [RW-1:0] r_c_q;
  sector_e       sector_d, sector_q;
  logic          vld_c_q;

  assign sector_d = sector_e'(3'(qa_b_q - QA_W'(qq_q) * QA_W'(6)));

  always_ff @(posedge clk_i) begin
    r_c_q    <= r_q;
    sector_q <= sector_d;
  end

  // beat valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  assign ctl_o.vld    = vld_c_q;
  assign ctl_o.sector = sector_q;
  assign rem_o        = r_c_q;

endmodule

[src/hta_chan_lane.sv]
// hta_chan_lane: four-stage scaling of one colour channel to 0..255
// depends on hta_pkg
module hta_chan_lane import hta_pkg::*; #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                     clk_i,
  input  logic [LEVEL_W-1:0]       s_i,
  input  logic [V255_W-1:0]        v255_i,
  input  logic [HUE_FRAC_BITS+5:0] k_i,
  output logic [CHAN_W-1:0]        chan_o
);

  localparam int unsigned SKW = HUE_FRAC_BITS + 16;
  localparam int unsigned PW  = HUE_FRAC_BITS + 32;
  localparam int unsigned SH  = HUE_FRAC_BITS + 16;
  localparam int unsigned DW  = M_W + 15;
  localparam logic [SKW-1:0] FULL_SCALE = SKW'(SPAN_DEG) << (HUE_FRAC_BITS + 8);
  localparam logic [PW-1:0]  ROUND_HALF = PW'(SPAN_DEG) << (HUE_FRAC_BITS + 15);

  // stage 1: saturation times offset
  logic [SKW-1:0] sk_d, sk_q;
  assign sk_d = SKW'(s_i) * SKW'(k_i);

  // stage 2: level left below full scale
  logic [SKW-1:0] inner_d, inner_q;
  assign inner_d = FULL_SCALE - sk_q;

  // stage 3: times 255*v, add the rounding half, drop the power-of-two part
  logic [PW-1:0]  num;
  logic [M_W-1:0] m_d, m_q;
  assign num = PW'(v255_i) * PW'(inner_q) + ROUND_HALF;
  assign m_d = num[SH +: M_W];

  // stage 4: divide by 60 through the reciprocal
  logic [DW-1:0]     quo;
  logic [CHAN_W-1:0] chan_d, chan_q;
  assign quo    = DW'(m_q) * DW'(CH_DIV_MUL);
  assign chan_d = quo[CH_DIV_SH +: CHAN_W];

  always_ff @(posedge clk_i) begin
    sk_q    <= sk_d;
    inner_q <= inner_d;
    m_q     <= m_d;
    chan_q  <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

[src/hsv_to_argb_converter.sv]
// hsv_to_argb_converter: top level, configuration registers, channel lanes and packing
// depends on hta_pkg, hta_hue_split and hta_chan_lane
//
// One hue beat is taken on every clock cycle (busy_o never rises) and its ARGB
// word appears on argb_word_o with done_o high after three stages of hue
// reduction, four stages in each channel lane (multiply, subtract, multiply
// with rounding, reciprocal divide by 60) and one output register.
// Results cannot be held off; each is shown for one cycle only. Saturation and
// brightness are Q1.8 levels with 256 as 1.0, values above 256 act as 256; write
// them only while no beat is in flight.
module hsv_to_argb_converter import hta_pkg::*; #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [HUE_W-1:0]     hue_angle_i,
  output logic                 done_o,
  output logic [ARGB_W-1:0]    argb_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_wdata_i
);

  localparam int unsigned KW      = HUE_FRAC_BITS + 6;
  localparam int unsigned LANE_LAT = 4;
  localparam logic [KW-1:0] SPAN = KW'(SPAN_DEG) << HUE_FRAC_BITS;

  // configuration registers
  logic [LEVEL_W-1:0] sat_q, bri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= LEVEL_ONE;
      bri_q <= LEVEL_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SATURATION: sat_q <= cfg_wdata_i;
        CFG_BRIGHTNESS: bri_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // levels limited to 1.0, and 255*v
  logic [LEVEL_W-1:0] s_lvl, v_lvl;
  logic [V255_W-1:0]  v255;
  assign s_lvl = (sat_q > LEVEL_ONE) ? LEVEL_ONE : sat_q;
  assign v_lvl = (bri_q > LEVEL_ONE) ? LEVEL_ONE : bri_q;
  assign v255  = V255_W'({v_lvl, 8'd0} - {8'd0, v_lvl});

  // every beat is taken
  assign busy_o = 1'b0;

  // hue reduction
  split_ctl_t    split_ctl;
  logic [KW-1:0] rem;

  hta_hue_split #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_split (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (start_i),
    .hue_i (hue_angle_i),
    .ctl_o (split_ctl),
    .rem_o (rem)
  );

  // lane offsets: v none, p full span, q the remainder, t its complement
  logic [KW-1:0]     k_lane [4];
  logic [CHAN_W-1:0] c_lane [4];
  assign k_lane[0] = '0;
  assign k_lane[1] = SPAN;
  assign k_lane[2] = rem;
  assign k_lane[3] = SPAN - rem;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    hta_chan_lane #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .s_i   (s_lvl),
      .v255_i(v255),
      .k_i   (k_lane[g]),
      .chan_o(c_lane[g])
    );
  end

  // sector and valid follow the lanes
  sector_e sect_q [LANE_LAT];
  logic    vld_q  [LANE_LAT];

  always_ff @(posedge clk_i) begin
    sect_q[0] <= split_ctl.sector;
    for (int i = 1; i < LANE_LAT; i++) begin
      sect_q[i] <= sect_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= split_ctl.vld;
      for (int i = 1; i < LANE_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // channel choice by sector
  logic [CHAN_W-1:0] red, green, blue;
  logic [CHAN_W-1:0] cv, cp, cq, ct;
  assign cv = c_lane[0];
  assign cp = c_lane[1];
  assign cq = c_lane[2];
  assign ct = c_lane[3];

  always_comb begin
    unique case (sect_q[LANE_LAT-1])
      SECT_RED_YELLOW: begin red = cv; green = ct; blue = cp; end
      SECT_YELLOW_GRN: begin red = cq; green = cv; blue = cp; end
      SECT_GRN_CYAN:   begin red = cp; green = cv; blue = ct; end
      SECT_CYAN_BLUE:  begin red = cp; green = cq; blue = cv; end
      SECT_BLUE_MAG:   begin red = ct; green = cp; blue = cv; end
      default:         begin red = cv; green = cp; blue = cq; end
    endcase
  end

  // output beat register
  logic [ARGB_W-1:0] argb_d, argb_q;
  logic              done_q;
  assign argb_d = {ALPHA_OPAQUE, red, green, blue};

  always_ff @(posedge clk_i) begin
    argb_q <= argb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LANE_LAT-1];
    end
  end

  assign done_o      = done_q;
  assign argb_word_o = argb_q;

endmodule
